// File: hdl/ptrk_pkg.sv
// Shared types, constants and saturation helpers for the pointer drag tracker.
// Used by every module of the block; depends on nothing else.
package ptrk_pkg;

  localparam int TOUCH_SLOTS = 8;
  localparam int SLOT_IW = (TOUCH_SLOTS > 1) ? $clog2(TOUCH_SLOTS) : 1;

  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-3:0] REG_DRAG_THRESHOLD = '0;
  localparam logic [15:0] DRAG_THRESHOLD_RESET = 16'd64;
  localparam logic [31:0] THRESHOLD_SQ_RESET = 32'd4096;

  typedef enum logic [3:0] {
    MODE_RESET       = 4'd0,
    MODE_FRAME       = 4'd1,
    MODE_MOVE        = 4'd2,
    MODE_PRESS       = 4'd3,
    MODE_RELEASE     = 4'd4,
    MODE_WHEEL       = 4'd5,
    MODE_POLL        = 4'd6,
    MODE_TOUCH_BEGIN = 4'd7,
    MODE_TOUCH_MOVE  = 4'd8,
    MODE_TOUCH_END   = 4'd9,
    MODE_QUERY_MOUSE = 4'd10,
    MODE_QUERY_TOUCH = 4'd11
  } ptrk_mode_t;

  localparam int F_DOWN   = 0;
  localparam int F_PRESS  = 1;
  localparam int F_REL    = 2;
  localparam int F_DRAG   = 3;
  localparam int F_DSTART = 4;
  localparam int F_DEND   = 5;
  localparam logic [5:0] FRAME_MASK = 6'b110110;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [16:0] del_x;
    logic signed [16:0] del_y;
    logic signed [15:0] org_x;
    logic signed [15:0] org_y;
    logic [5:0]         flags;
  } ptrk_rec_t;

  typedef struct packed {
    logic move_en;
    logic load_pos;
    logic down_en;
    logic down_val;
  } ptrk_op_t;

  typedef struct packed {
    logic               hit;
    logic               free;
    logic [SLOT_IW-1:0] idx;
    ptrk_rec_t          rec;
  } ptrk_lookup_t;

  function automatic logic signed [16:0] sat17(input logic signed [18:0] v);
    logic signed [16:0] r;
    if (v < -19'sd65536) begin
      r = -17'sd65536;
    end else if (v > 19'sd65535) begin
      r = 17'sd65535;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [20:0] v);
    logic signed [19:0] r;
    if (v < -21'sd524288) begin
      r = -20'sd524288;
    end else if (v > 21'sd524287) begin
      r = 20'sd524287;
    end else begin
      r = v[19:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/ptrk_ptr_update.sv
// Next-state logic for one pointer record: move, drag test and button edges.
// Purely combinational; depends on ptrk_pkg.
module ptrk_ptr_update
  import ptrk_pkg::*;
(
  input  ptrk_rec_t          rec,
  input  ptrk_op_t           op,
  input  logic               seen,
  input  logic signed [15:0] new_x,
  input  logic signed [15:0] new_y,
  input  logic [31:0]        thr_sq,
  output ptrk_rec_t          rec_next
);

  logic signed [18:0] sum_x;
  logic signed [18:0] sum_y;
  logic signed [16:0] ex;
  logic signed [16:0] ey;
  logic signed [33:0] sqx;
  logic signed [33:0] sqy;
  logic [32:0]        dist_sq;
  logic               drag_hit;
  ptrk_rec_t          m;

  assign sum_x = $signed({{2{rec.del_x[16]}}, rec.del_x}) + $signed({{3{new_x[15]}}, new_x})
               - $signed({{3{rec.pos_x[15]}}, rec.pos_x});
  assign sum_y = $signed({{2{rec.del_y[16]}}, rec.del_y}) + $signed({{3{new_y[15]}}, new_y})
               - $signed({{3{rec.pos_y[15]}}, rec.pos_y});

  assign ex = $signed({new_x[15], new_x}) - $signed({rec.org_x[15], rec.org_x});
  assign ey = $signed({new_y[15], new_y}) - $signed({rec.org_y[15], rec.org_y});
  assign sqx = ex * ex;
  assign sqy = ey * ey;
  assign dist_sq = {1'b0, sqx[31:0]} + {1'b0, sqy[31:0]};
  assign drag_hit = ({dist_sq, 8'h00} >= {9'd0, thr_sq});

  always_comb begin
    m = rec;
    if (op.load_pos) begin
      m.pos_x = new_x;
      m.pos_y = new_y;
      m.del_x = '0;
      m.del_y = '0;
    end else if (op.move_en) begin
      m.pos_x = new_x;
      m.pos_y = new_y;
      if (seen) begin
        m.del_x = sat17(sum_x);
        m.del_y = sat17(sum_y);
        if (rec.flags[F_DOWN] && !rec.flags[F_DRAG] && drag_hit) begin
          m.flags[F_DRAG]   = 1'b1;
          m.flags[F_DSTART] = 1'b1;
        end
      end
    end
    if (op.down_en && (m.flags[F_DOWN] != op.down_val)) begin
      if (op.down_val) begin
        m.flags[F_DOWN]  = 1'b1;
        m.flags[F_PRESS] = 1'b1;
        m.flags[F_DRAG]  = 1'b0;
        m.org_x = m.pos_x;
        m.org_y = m.pos_y;
      end else begin
        m.flags[F_DOWN] = 1'b0;
        m.flags[F_REL]  = 1'b1;
        m.flags[F_DEND] = m.flags[F_DRAG];
        m.flags[F_DRAG] = 1'b0;
      end
    end
    rec_next = m;
  end

endmodule

// File: hdl/ptrk_slot_table.sv
// Touch slot table: finger match, free slot search, write-back and frame pruning.
// Depends on ptrk_pkg.
module ptrk_slot_table
  import ptrk_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         finger,
  input  logic               clear_all,
  input  logic               frame,
  input  logic               wr_en,
  input  logic [SLOT_IW-1:0] wr_idx,
  input  ptrk_rec_t          wr_rec,
  output ptrk_lookup_t       lookup
);

  logic [TOUCH_SLOTS-1:0] slot_valid;
  logic [7:0]             slot_finger [TOUCH_SLOTS];
  ptrk_rec_t              slot_rec    [TOUCH_SLOTS];
  logic                   hit;
  logic                   free;
  logic [SLOT_IW-1:0]     hit_idx;
  logic [SLOT_IW-1:0]     free_idx;

  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int k = TOUCH_SLOTS - 1; k >= 0; k--) begin
      if (slot_valid[k] && (slot_finger[k] == finger)) begin
        hit     = 1'b1;
        hit_idx = SLOT_IW'(k);
      end
      if (!slot_valid[k]) begin
        free     = 1'b1;
        free_idx = SLOT_IW'(k);
      end
    end
    lookup.hit  = hit;
    lookup.free = free;
    lookup.idx  = hit ? hit_idx : free_idx;
    lookup.rec  = hit ? slot_rec[hit_idx] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (clear_all) begin
      slot_valid <= '0;
    end else if (frame) begin
      for (int k = 0; k < TOUCH_SLOTS; k++) begin
        if (!slot_rec[k].flags[F_DOWN] && slot_rec[k].flags[F_REL]) begin
          slot_valid[k] <= 1'b0;
        end
      end
    end else if (wr_en) begin
      slot_valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (frame) begin
      for (int k = 0; k < TOUCH_SLOTS; k++) begin
        slot_rec[k].del_x <= '0;
        slot_rec[k].del_y <= '0;
        slot_rec[k].flags <= slot_rec[k].flags & ~FRAME_MASK;
      end
    end else if (wr_en) begin
      slot_rec[wr_idx]    <= wr_rec;
      slot_finger[wr_idx] <= finger;
    end
  end

endmodule

// File: hdl/pointer_drag_tracker.sv
// Top level of the pointer drag tracker: event register, mouse state, register port
// and result register. Depends on ptrk_pkg, ptrk_ptr_update and ptrk_slot_table.
//
// Usage. Input events arrive on the event channel (event_valid/event_ready) with
// their mode and fields. Every event yields exactly one item on the report channel
// (report_valid/report_ready), in order. An accepted event is held in an input
// register and is processed once the output register is free or being emptied; the
// report is then written to the output register. While the receiver keeps up, one
// event can be taken in every cycle, so the sustained rate is one item per cycle.
// The slot match over the touch table and the squared-distance drag test both sit
// in the combinational logic between the input register and the output register.
// When the receiver stalls, the output register holds its report, the event held
// in the input register waits, and event_ready falls once both are occupied.
// The drag threshold is written through the APB port at byte address 0 and its
// square is registered at the write. Reset clears all pointer state, empties the
// touch table and sets the threshold to 4.0 pixels; a reset event does the same
// but keeps the threshold.
module pointer_drag_tracker
  import ptrk_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                event_valid,
  output logic                event_ready,
  input  logic [3:0]          mode,
  input  logic signed [15:0]  pos_x,
  input  logic signed [15:0]  pos_y,
  input  logic [7:0]          pointer_id,
  input  logic                left_button,
  input  logic                wheel_is_vertical,
  input  logic signed [15:0]  wheel_step,
  output logic                report_valid,
  input  logic                report_ready,
  output logic                device,
  output logic [7:0]          reported_id,
  output logic                found,
  output logic signed [15:0]  screen_x,
  output logic signed [15:0]  screen_y,
  output logic signed [16:0]  move_x,
  output logic signed [16:0]  move_y,
  output logic [5:0]          flags,
  output logic signed [19:0]  wheel_sum_v,
  output logic signed [19:0]  wheel_sum_h,
  output logic                table_full
);

  logic [15:0]        drag_threshold;
  logic [31:0]        thr_sq;
  logic               cfg_sel;

  logic               ev_full;
  logic [3:0]         ev_mode;
  logic signed [15:0] ev_x;
  logic signed [15:0] ev_y;
  logic [7:0]         ev_id;
  logic               ev_left;
  logic               ev_vert;
  logic signed [15:0] ev_step;
  logic               process;

  ptrk_rec_t          mouse_rec;
  ptrk_rec_t          mouse_rec_next;
  logic               mouse_seen;
  logic               mouse_seen_next;
  logic signed [19:0] wheel_v;
  logic signed [19:0] wheel_v_next;
  logic signed [19:0] wheel_h;
  logic signed [19:0] wheel_h_next;
  logic signed [20:0] wheel_sel_sum;

  ptrk_mode_t         mode_e;
  ptrk_op_t           op;
  logic               is_touch_ev;
  logic               is_touch;
  logic               touch_ok;
  ptrk_lookup_t       lookup;
  ptrk_rec_t          upd_in;
  ptrk_rec_t          upd_out;
  logic               upd_seen;

  logic               res_device;
  logic [7:0]         res_id;
  logic               res_found;
  ptrk_rec_t          res_rec;
  logic signed [19:0] res_wv;
  logic signed [19:0] res_wh;
  logic               res_full;

  // Register port.
  assign pready  = 1'b1;
  assign cfg_sel = (paddr[PADDR_W-1:2] == REG_DRAG_THRESHOLD);
  assign prdata  = cfg_sel ? {16'd0, drag_threshold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      drag_threshold <= DRAG_THRESHOLD_RESET;
      thr_sq         <= THRESHOLD_SQ_RESET;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      drag_threshold <= pwdata[15:0];
      thr_sq         <= 32'(pwdata[15:0]) * 32'(pwdata[15:0]);
    end
  end

  // Input register.
  assign process     = ev_full && (!report_valid || report_ready);
  assign event_ready = !ev_full || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_full <= 1'b0;
    end else if (event_valid && event_ready) begin
      ev_full <= 1'b1;
    end else if (process) begin
      ev_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (event_valid && event_ready) begin
      ev_mode <= mode;
      ev_x    <= pos_x;
      ev_y    <= pos_y;
      ev_id   <= pointer_id;
      ev_left <= left_button;
      ev_vert <= wheel_is_vertical;
      ev_step <= wheel_step;
    end
  end

  // Event decode.
  assign mode_e = ptrk_mode_t'(ev_mode);

  always_comb begin
    op          = '0;
    is_touch_ev = 1'b0;
    is_touch    = 1'b0;
    unique case (mode_e)
      MODE_MOVE, MODE_WHEEL: begin
        op.move_en = 1'b1;
      end
      MODE_PRESS, MODE_RELEASE: begin
        op.move_en  = 1'b1;
        op.down_en  = ev_left;
        op.down_val = (mode_e == MODE_PRESS);
      end
      MODE_POLL: begin
        op.move_en  = 1'b1;
        op.down_en  = 1'b1;
        op.down_val = ev_left;
      end
      MODE_TOUCH_BEGIN: begin
        op.load_pos = 1'b1;
        op.down_en  = 1'b1;
        op.down_val = 1'b1;
        is_touch_ev = 1'b1;
        is_touch    = 1'b1;
      end
      MODE_TOUCH_MOVE: begin
        op.move_en  = 1'b1;
        is_touch_ev = 1'b1;
        is_touch    = 1'b1;
      end
      MODE_TOUCH_END: begin
        op.move_en  = 1'b1;
        op.down_en  = 1'b1;
        op.down_val = 1'b0;
        is_touch_ev = 1'b1;
        is_touch    = 1'b1;
      end
      MODE_QUERY_TOUCH: begin
        is_touch = 1'b1;
      end
      default: begin
        op = '0;
      end
    endcase
  end

  ptrk_slot_table u_slots (
    .clk       (clk),
    .rst       (rst),
    .finger    (ev_id),
    .clear_all (process && (mode_e == MODE_RESET)),
    .frame     (process && (mode_e == MODE_FRAME)),
    .wr_en     (process && is_touch_ev && touch_ok),
    .wr_idx    (lookup.idx),
    .wr_rec    (upd_out),
    .lookup    (lookup)
  );

  assign touch_ok = lookup.hit || lookup.free;
  assign upd_in   = is_touch ? lookup.rec : mouse_rec;
  assign upd_seen = is_touch ? 1'b1 : mouse_seen;

  ptrk_ptr_update u_update (
    .rec      (upd_in),
    .op       (op),
    .seen     (upd_seen),
    .new_x    (ev_x),
    .new_y    (ev_y),
    .thr_sq   (thr_sq),
    .rec_next (upd_out)
  );

  // Mouse state.
  assign wheel_sel_sum = $signed({(ev_vert ? wheel_v[19] : wheel_h[19]),
                                  (ev_vert ? wheel_v : wheel_h)})
                       + $signed({{5{ev_step[15]}}, ev_step});

  always_comb begin
    mouse_rec_next  = mouse_rec;
    mouse_seen_next = mouse_seen;
    wheel_v_next    = wheel_v;
    wheel_h_next    = wheel_h;
    case (mode_e)
      MODE_RESET: begin
        mouse_rec_next  = '0;
        mouse_seen_next = 1'b0;
        wheel_v_next    = '0;
        wheel_h_next    = '0;
      end
      MODE_FRAME: begin
        mouse_rec_next.del_x = '0;
        mouse_rec_next.del_y = '0;
        mouse_rec_next.flags = mouse_rec.flags & ~FRAME_MASK;
        wheel_v_next         = '0;
        wheel_h_next         = '0;
      end
      MODE_MOVE, MODE_PRESS, MODE_RELEASE, MODE_POLL: begin
        mouse_rec_next  = upd_out;
        mouse_seen_next = 1'b1;
      end
      MODE_WHEEL: begin
        mouse_rec_next  = upd_out;
        mouse_seen_next = 1'b1;
        if (ev_vert) begin
          wheel_v_next = sat20(wheel_sel_sum);
        end else begin
          wheel_h_next = sat20(wheel_sel_sum);
        end
      end
      default: begin
        mouse_seen_next = mouse_seen;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mouse_rec  <= '0;
      mouse_seen <= 1'b0;
      wheel_v    <= '0;
      wheel_h    <= '0;
    end else if (process) begin
      mouse_rec  <= mouse_rec_next;
      mouse_seen <= mouse_seen_next;
      wheel_v    <= wheel_v_next;
      wheel_h    <= wheel_h_next;
    end
  end

  // Result selection.
  always_comb begin
    res_device = 1'b0;
    res_id     = 8'd0;
    res_found  = 1'b1;
    res_rec    = mouse_rec_next;
    res_wv     = wheel_v_next;
    res_wh     = wheel_h_next;
    res_full   = 1'b0;
    if (is_touch) begin
      res_device = 1'b1;
      res_id     = ev_id;
      res_wv     = '0;
      res_wh     = '0;
      res_found  = is_touch_ev ? touch_ok : lookup.hit;
      res_full   = is_touch_ev && !touch_ok;
      res_rec    = res_found ? upd_out : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (process) begin
      report_valid <= 1'b1;
    end else if (report_ready) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      device      <= res_device;
      reported_id <= res_id;
      found       <= res_found;
      screen_x    <= res_rec.pos_x;
      screen_y    <= res_rec.pos_y;
      move_x      <= res_rec.del_x;
      move_y      <= res_rec.del_y;
      flags       <= res_rec.flags;
      wheel_sum_v <= res_wv;
      wheel_sum_h <= res_wh;
      table_full  <= res_full;
    end
  end

  // The mouse is always present in its reports.
  a_mouse_found: assert property (@(posedge clk) disable iff (rst)
    report_valid && !device |-> found)
    else $error("mouse report without found");

  // A dropped touch event is reported as a touch that was not found.
  a_full_report: assert property (@(posedge clk) disable iff (rst)
    report_valid && table_full |-> device && !found)
    else $error("table full report is inconsistent");

  // A pointer that was not found reports empty fields.
  a_missing_empty: assert property (@(posedge clk) disable iff (rst)
    report_valid && !found |-> (flags == 6'd0) && (move_x == 17'sd0) && (screen_x == 16'sd0))
    else $error("missing pointer reports nonzero fields");

  // Dragging is only possible while the pointer is down.
  a_drag_down: assert property (@(posedge clk) disable iff (rst)
    report_valid && found && flags[F_DRAG] |-> flags[F_DOWN])
    else $error("dragging reported while not down");

endmodule

// File: test/ptrk_checker.sv
`timescale 1ns / 1ps
// Checker for the pointer drag tracker: watches the register port and both item channels,
// keeps its own copy of mouse, wheel and touch table state, and compares every report.
// Depends on ptrk_pkg for the mode codes, flag positions and register address.
module ptrk_checker
  import ptrk_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  input  logic                event_valid,
  input  logic                event_ready,
  input  logic [3:0]          mode,
  input  logic signed [15:0]  pos_x,
  input  logic signed [15:0]  pos_y,
  input  logic [7:0]          pointer_id,
  input  logic                left_button,
  input  logic                wheel_is_vertical,
  input  logic signed [15:0]  wheel_step,
  input  logic                report_valid,
  input  logic                report_ready,
  input  logic                device,
  input  logic [7:0]          reported_id,
  input  logic                found,
  input  logic signed [15:0]  screen_x,
  input  logic signed [15:0]  screen_y,
  input  logic signed [16:0]  move_x,
  input  logic signed [16:0]  move_y,
  input  logic [5:0]          flags,
  input  logic signed [19:0]  wheel_sum_v,
  input  logic signed [19:0]  wheel_sum_h,
  input  logic                table_full,
  output int                  errors,
  output int                  pending,
  output int                  reports
);

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic [5:0]         fl;
  } track_t;

  typedef struct packed {
    logic               dev;
    logic [7:0]         id;
    logic               fnd;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [16:0] mx;
    logic signed [16:0] my;
    logic [5:0]         fl;
    logic signed [19:0] wv;
    logic signed [19:0] wh;
    logic               full;
  } report_t;

  logic [15:0]        drag_thr;
  logic               mouse_seen;
  track_t             mouse;
  logic signed [31:0] wheel_v;
  logic signed [31:0] wheel_h;
  logic               slot_on  [TOUCH_SLOTS];
  logic [7:0]         slot_fid [TOUCH_SLOTS];
  track_t             slot_trk [TOUCH_SLOTS];
  report_t            owed_reports[$];

  function automatic logic signed [31:0] clip(longint v, longint lo, longint hi);
    if (v < lo) begin
      return 32'(lo);
    end
    if (v > hi) begin
      return 32'(hi);
    end
    return 32'(v);
  endfunction

  function automatic track_t drag_check(track_t t);
    longint ex;
    longint ey;
    longint lim;
    if (!t.fl[F_DOWN] || t.fl[F_DRAG]) begin
      return t;
    end
    ex = longint'(t.px) - longint'(t.ox);
    ey = longint'(t.py) - longint'(t.oy);
    lim = longint'(drag_thr) * longint'(drag_thr);
    if ((ex * ex + ey * ey) * 256 >= lim) begin
      t.fl[F_DRAG] = 1'b1;
      t.fl[F_DSTART] = 1'b1;
    end
    return t;
  endfunction

  function automatic track_t move_track(track_t t, longint nx, longint ny);
    t.dx = clip(longint'(t.dx) + nx - longint'(t.px), -65536, 65535);
    t.dy = clip(longint'(t.dy) + ny - longint'(t.py), -65536, 65535);
    t.px = 32'(nx);
    t.py = 32'(ny);
    return drag_check(t);
  endfunction

  function automatic track_t set_level(track_t t, logic d);
    if (t.fl[F_DOWN] == d) begin
      return t;
    end
    if (d) begin
      t.fl[F_DOWN] = 1'b1;
      t.fl[F_PRESS] = 1'b1;
      t.fl[F_DRAG] = 1'b0;
      t.ox = t.px;
      t.oy = t.py;
    end else begin
      t.fl[F_DOWN] = 1'b0;
      t.fl[F_REL] = 1'b1;
      t.fl[F_DEND] = t.fl[F_DRAG];
      t.fl[F_DRAG] = 1'b0;
    end
    return t;
  endfunction

  function automatic report_t fill(report_t r, track_t t, logic signed [31:0] v,
                                   logic signed [31:0] h);
    r.fnd = 1'b1;
    r.sx = t.px[15:0];
    r.sy = t.py[15:0];
    r.mx = t.dx[16:0];
    r.my = t.dy[16:0];
    r.fl = t.fl;
    r.wv = v[19:0];
    r.wh = h[19:0];
    return r;
  endfunction

  function automatic int find_slot(logic [7:0] fid);
    for (int k = 0; k < TOUCH_SLOTS; k++) begin
      if (slot_on[k] && slot_fid[k] == fid) begin
        return k;
      end
    end
    return -1;
  endfunction

  task automatic clear_pointers();
    mouse_seen = 1'b0;
    mouse = '0;
    wheel_v = 0;
    wheel_h = 0;
    for (int k = 0; k < TOUCH_SLOTS; k++) begin
      slot_on[k] = 1'b0;
      slot_fid[k] = '0;
      slot_trk[k] = '0;
    end
  endtask

  task automatic mouse_step(logic signed [31:0] nx, logic signed [31:0] ny);
    if (!mouse_seen) begin
      mouse.px = nx;
      mouse.py = ny;
      mouse_seen = 1'b1;
    end else begin
      mouse = move_track(mouse, nx, ny);
    end
  endtask

  task automatic flag_error(input string msg);
    errors++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic predict_event();
    int k;
    logic touch;
    report_t r;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    nx = 32'(pos_x);
    ny = 32'(pos_y);
    r = '0;
    touch = 1'b0;
    case (mode)
      MODE_RESET: begin
        clear_pointers();
      end
      MODE_FRAME: begin
        for (int j = 0; j < TOUCH_SLOTS; j++) begin
          if (slot_on[j] && !slot_trk[j].fl[F_DOWN] && slot_trk[j].fl[F_REL]) begin
            slot_on[j] = 1'b0;
          end
          slot_trk[j].dx = 0;
          slot_trk[j].dy = 0;
          slot_trk[j].fl = slot_trk[j].fl & ~FRAME_MASK;
        end
        mouse.dx = 0;
        mouse.dy = 0;
        mouse.fl = mouse.fl & ~FRAME_MASK;
        wheel_v = 0;
        wheel_h = 0;
      end
      MODE_MOVE: begin
        mouse_step(nx, ny);
      end
      MODE_PRESS, MODE_RELEASE: begin
        mouse_step(nx, ny);
        if (left_button) begin
          mouse = set_level(mouse, mode == MODE_PRESS);
        end
      end
      MODE_WHEEL: begin
        mouse_step(nx, ny);
        if (wheel_is_vertical) begin
          wheel_v = clip(longint'(wheel_v) + longint'(wheel_step), -524288, 524287);
        end else begin
          wheel_h = clip(longint'(wheel_h) + longint'(wheel_step), -524288, 524287);
        end
      end
      MODE_POLL: begin
        mouse_step(nx, ny);
        mouse = set_level(mouse, left_button);
      end
      MODE_TOUCH_BEGIN, MODE_TOUCH_MOVE, MODE_TOUCH_END: begin
        touch = 1'b1;
        r.dev = 1'b1;
        r.id = pointer_id;
        k = find_slot(pointer_id);
        for (int j = 0; j < TOUCH_SLOTS && k < 0; j++) begin
          if (!slot_on[j]) begin
            k = j;
            slot_on[j] = 1'b1;
            slot_fid[j] = pointer_id;
            slot_trk[j] = '0;
          end
        end
        if (k < 0) begin
          r.full = 1'b1;
        end else begin
          if (mode == MODE_TOUCH_BEGIN) begin
            slot_trk[k].px = nx;
            slot_trk[k].py = ny;
            slot_trk[k].dx = 0;
            slot_trk[k].dy = 0;
            slot_trk[k] = set_level(slot_trk[k], 1'b1);
          end else begin
            slot_trk[k] = move_track(slot_trk[k], nx, ny);
            if (mode == MODE_TOUCH_END) begin
              slot_trk[k] = set_level(slot_trk[k], 1'b0);
            end
          end
          r = fill(r, slot_trk[k], 0, 0);
        end
      end
      MODE_QUERY_TOUCH: begin
        touch = 1'b1;
        r.dev = 1'b1;
        r.id = pointer_id;
        k = find_slot(pointer_id);
        if (k >= 0) begin
          r = fill(r, slot_trk[k], 0, 0);
        end
      end
      default: begin
      end
    endcase
    if (!touch) begin
      r = fill(r, mouse, wheel_v, wheel_h);
    end
    owed_reports = {owed_reports, r};
  endtask

  always @(posedge clk) begin : watch
    report_t got;
    report_t want;
    if (rst) begin
      clear_pointers();
      drag_thr = DRAG_THRESHOLD_RESET;
      owed_reports.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_DRAG_THRESHOLD) begin
        drag_thr = pwdata[15:0];
      end
      if (report_valid && report_ready) begin
        reports++;
        got = {device, reported_id, found, screen_x, screen_y, move_x, move_y, flags,
               wheel_sum_v, wheel_sum_h, table_full};
        if (owed_reports.size() == 0) begin
          flag_error("report arrived with no event outstanding");
        end else begin
          want = owed_reports.pop_front();
          check_field("device", got.dev, want.dev);
          check_field("reported_id", got.id, want.id);
          check_field("found", got.fnd, want.fnd);
          check_field("screen_x", got.sx, want.sx);
          check_field("screen_y", got.sy, want.sy);
          check_field("move_x", got.mx, want.mx);
          check_field("move_y", got.my, want.my);
          check_field("flags", got.fl, want.fl);
          check_field("wheel_sum_v", got.wv, want.wv);
          check_field("wheel_sum_h", got.wh, want.wh);
          check_field("table_full", got.full, want.full);
        end
      end
      if (event_valid && event_ready) begin
        predict_event();
      end
    end
    pending <= owed_reports.size();
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Top of the pointer drag tracker testbench: clock, reset, register writes, event stimulus
// and a stalling receiver. Depends on ptrk_pkg, pointer_drag_tracker and ptrk_checker.
module tb_top
  import ptrk_pkg::*;
();

  localparam int PHASES = 7;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int STALL_LIMIT = 2000;
  localparam logic [PADDR_W-1:0] THR_ADDR = {REG_DRAG_THRESHOLD, 2'b00};

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         id;
    logic               left;
    logic               vert;
    logic signed [15:0] step;
  } ev_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic event_valid = 1'b0;
  logic event_ready;
  logic [3:0] mode = '0;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic [7:0] pointer_id = '0;
  logic left_button = 1'b0;
  logic wheel_is_vertical = 1'b0;
  logic signed [15:0] wheel_step = '0;
  logic report_valid;
  logic report_ready = 1'b0;
  logic device;
  logic [7:0] reported_id;
  logic found;
  logic signed [15:0] screen_x;
  logic signed [15:0] screen_y;
  logic signed [16:0] move_x;
  logic signed [16:0] move_y;
  logic [5:0] flags;
  logic signed [19:0] wheel_sum_v;
  logic signed [19:0] wheel_sum_h;
  logic table_full;

  int mon_errors;
  int mon_pending;
  int mon_reports;
  int items_sent = 0;
  int burst_left = 0;
  logic tx_steady = 1'b0;
  int idle_cycles = 0;
  int rx_style = 0;
  int rx_stall = 0;
  int rx_cycle = 0;

  always #1 clk = ~clk;

  pointer_drag_tracker dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .event_valid(event_valid), .event_ready(event_ready),
    .mode(mode), .pos_x(pos_x), .pos_y(pos_y), .pointer_id(pointer_id),
    .left_button(left_button), .wheel_is_vertical(wheel_is_vertical),
    .wheel_step(wheel_step),
    .report_valid(report_valid), .report_ready(report_ready),
    .device(device), .reported_id(reported_id), .found(found),
    .screen_x(screen_x), .screen_y(screen_y), .move_x(move_x), .move_y(move_y),
    .flags(flags), .wheel_sum_v(wheel_sum_v), .wheel_sum_h(wheel_sum_h),
    .table_full(table_full)
  );

  ptrk_checker tracker_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
    .pwdata(pwdata),
    .event_valid(event_valid), .event_ready(event_ready),
    .mode(mode), .pos_x(pos_x), .pos_y(pos_y), .pointer_id(pointer_id),
    .left_button(left_button), .wheel_is_vertical(wheel_is_vertical),
    .wheel_step(wheel_step),
    .report_valid(report_valid), .report_ready(report_ready),
    .device(device), .reported_id(reported_id), .found(found),
    .screen_x(screen_x), .screen_y(screen_y), .move_x(move_x), .move_y(move_y),
    .flags(flags), .wheel_sum_v(wheel_sum_v), .wheel_sum_h(wheel_sum_h),
    .table_full(table_full),
    .errors(mon_errors), .pending(mon_pending), .reports(mon_reports)
  );

  // The receiver switches between always ready, coin-toss ready and long stalls.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 150 == 0) begin
      rx_style <= $urandom_range(0, 2);
    end
    if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
      report_ready <= 1'b0;
    end else if (rx_style == 0) begin
      report_ready <= 1'b1;
    end else if (rx_style == 1) begin
      report_ready <= 1'($urandom_range(0, 1));
    end else if ($urandom_range(0, 9) == 0) begin
      rx_stall <= $urandom_range(1, 31);
      report_ready <= 1'b0;
    end else begin
      report_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (event_valid && event_ready) || (report_valid && report_ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Timed out after %0d cycles without a handshake.", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic ev_t rand_ev();
    ev_t e;
    logic [31:0] r;
    r = $urandom();
    e.mode = r[3:0];
    e.id = r[11:4];
    e.left = r[12];
    e.vert = r[13];
    r = $urandom();
    e.x = r[15:0];
    e.y = r[31:16];
    r = $urandom();
    e.step = r[15:0];
    return e;
  endfunction

  function automatic ev_t mk(logic [3:0] m, int x, int y, int id, logic l, logic v, int s);
    ev_t e;
    e.mode = m;
    e.x = x[15:0];
    e.y = y[15:0];
    e.id = id[7:0];
    e.left = l;
    e.vert = v;
    e.step = s[15:0];
    return e;
  endfunction

  function automatic logic signed [15:0] nudge(logic signed [15:0] p, int span);
    int v;
    v = int'(p) + int'($urandom_range(0, 2 * span)) - span;
    if (v > 32767) begin
      v = 32767;
    end
    if (v < -32768) begin
      v = -32768;
    end
    return v[15:0];
  endfunction

  function automatic int pick_span();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) begin
      return 2;
    end else if (r < 7) begin
      return 40;
    end else if (r < 9) begin
      return 600;
    end
    return 20000;
  endfunction

  function automatic logic [7:0] pick_finger();
    if ($urandom_range(0, 9) < 7) begin
      return 8'($urandom_range(0, 11));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_event(input ev_t e);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = tx_steady ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(8, 40)
                                                        : $urandom_range(0, 3));
      if (gap != 0) begin
        event_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    event_valid <= 1'b1;
    mode <= e.mode;
    pos_x <= e.x;
    pos_y <= e.y;
    pointer_id <= e.id;
    left_button <= e.left;
    wheel_is_vertical <= e.vert;
    wheel_step <= e.step;
    do @(posedge clk); while (!event_ready);
    items_sent++;
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [31:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic settle();
    event_valid <= 1'b0;
    @(posedge clk);
    while (mon_pending != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic mouse_gesture();
    ev_t e;
    logic signed [15:0] px;
    logic signed [15:0] py;
    int span;
    span = pick_span();
    px = nudge(16'($urandom_range(0, 65535) - 32768), 0);
    py = nudge(16'($urandom_range(0, 65535) - 32768), 0);
    e = rand_ev();
    e.mode = MODE_MOVE;
    e.x = px;
    e.y = py;
    send_event(e);
    e = rand_ev();
    e.mode = ($urandom_range(0, 3) == 0) ? MODE_POLL : MODE_PRESS;
    e.left = ($urandom_range(0, 7) != 0);
    e.x = px;
    e.y = py;
    send_event(e);
    repeat ($urandom_range(0, 8)) begin
      px = nudge(px, span);
      py = nudge(py, span);
      e = rand_ev();
      e.mode = ($urandom_range(0, 5) == 0) ? MODE_WHEEL : MODE_MOVE;
      e.x = px;
      e.y = py;
      send_event(e);
    end
    if ($urandom_range(0, 5) != 0) begin
      e = rand_ev();
      e.x = nudge(px, span);
      e.y = nudge(py, span);
      if ($urandom_range(0, 1) == 0) begin
        e.mode = MODE_RELEASE;
        e.left = ($urandom_range(0, 7) != 0);
      end else begin
        e.mode = MODE_POLL;
        e.left = ($urandom_range(0, 7) == 0);
      end
      send_event(e);
    end
  endtask

  task automatic touch_gesture();
    ev_t e;
    logic [7:0] fid;
    logic signed [15:0] px;
    logic signed [15:0] py;
    int span;
    span = pick_span();
    fid = pick_finger();
    px = nudge(16'($urandom_range(0, 65535) - 32768), 0);
    py = nudge(16'($urandom_range(0, 65535) - 32768), 0);
    e = rand_ev();
    e.mode = MODE_TOUCH_BEGIN;
    e.id = fid;
    e.x = px;
    e.y = py;
    send_event(e);
    repeat ($urandom_range(0, 6)) begin
      px = nudge(px, span);
      py = nudge(py, span);
      e = rand_ev();
      e.mode = ($urandom_range(0, 4) == 0) ? MODE_QUERY_TOUCH : MODE_TOUCH_MOVE;
      e.id = fid;
      e.x = px;
      e.y = py;
      send_event(e);
    end
    if ($urandom_range(0, 4) != 0) begin
      e = rand_ev();
      e.mode = MODE_TOUCH_END;
      e.id = fid;
      e.x = nudge(px, span);
      e.y = nudge(py, span);
      send_event(e);
    end
  endtask

  task automatic wheel_run();
    ev_t e;
    logic signed [15:0] px;
    logic signed [15:0] py;
    px = nudge(16'($urandom_range(0, 65535) - 32768), 0);
    py = nudge(16'($urandom_range(0, 65535) - 32768), 0);
    repeat ($urandom_range(1, 20)) begin
      e = rand_ev();
      e.mode = MODE_WHEEL;
      e.x = px;
      e.y = py;
      if ($urandom_range(0, 1) == 0) begin
        e.step = e.step[15] ? 16'sh8000 : 16'sh7FFF;
      end
      send_event(e);
    end
  endtask

  initial begin
    ev_t e;
    logic [15:0] thr;
    int target;
    int pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed events at the reset threshold of 4.0 pixels.
    send_event(mk(MODE_QUERY_MOUSE, 0, 0, 0, 0, 0, 0));
    send_event(mk(MODE_MOVE, 100, -100, 0, 0, 0, 0));
    send_event(mk(MODE_MOVE, 32767, 32767, 0, 0, 0, 0));
    send_event(mk(MODE_MOVE, -32768, -32768, 0, 0, 0, 0));
    send_event(mk(MODE_MOVE, 32767, 32767, 0, 0, 0, 0));
    send_event(mk(MODE_PRESS, 32767, 32767, 0, 1, 0, 0));
    send_event(mk(MODE_PRESS, 32760, 32767, 0, 0, 0, 0));
    send_event(mk(MODE_MOVE, 32700, 32767, 0, 0, 0, 0));
    send_event(mk(MODE_RELEASE, 32700, 32767, 0, 1, 0, 0));
    send_event(mk(MODE_WHEEL, 32700, 32767, 0, 0, 1, 32767));
    send_event(mk(MODE_WHEEL, 32700, 32767, 0, 0, 0, -32768));
    send_event(mk(MODE_FRAME, 0, 0, 0, 0, 0, 0));
    send_event(mk(MODE_POLL, 0, 0, 0, 1, 0, 0));
    send_event(mk(MODE_POLL, 1, 1, 0, 0, 0, 0));
    send_event(mk(MODE_TOUCH_BEGIN, -32768, 32767, 0, 0, 0, 0));
    send_event(mk(MODE_TOUCH_MOVE, 32767, -32768, 0, 0, 0, 0));
    send_event(mk(MODE_QUERY_TOUCH, 0, 0, 0, 0, 0, 0));
    send_event(mk(MODE_QUERY_TOUCH, 0, 0, 255, 0, 0, 0));
    send_event(mk(MODE_TOUCH_END, 32767, -32768, 0, 0, 0, 0));
    send_event(mk(MODE_FRAME, 0, 0, 0, 0, 0, 0));
    send_event(mk(MODE_TOUCH_MOVE, 5, -5, 255, 1, 1, -1));
    send_event(mk(4'd12, 7, 7, 3, 1, 1, 1));
    send_event(mk(4'd15, -7, -7, 200, 0, 1, 2));
    send_event(mk(MODE_RESET, 9, 9, 9, 1, 1, 9));
    send_event(mk(MODE_MOVE, -1, -1, 0, 0, 0, 0));

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: thr = 16'd16;
        1: thr = 16'd0;
        2: thr = 16'hFFFF;
        3: thr = 16'($urandom_range(0, 65535));
        4: thr = DRAG_THRESHOLD_RESET;
        5: thr = 16'd1;
        default: thr = 16'($urandom_range(8, 2048));
      endcase
      apb_write(THR_ADDR, {16'h0000, thr});
      tx_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 1) begin
        e = rand_ev();
        e.mode = MODE_RESET;
        send_event(e);
      end
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          mouse_gesture();
        end else if (pick < 65) begin
          touch_gesture();
        end else if (pick < 74) begin
          send_event(mk(MODE_FRAME, $urandom(), $urandom(), $urandom(),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom()));
        end else if (pick < 81) begin
          wheel_run();
        end else if (pick < 90) begin
          e = rand_ev();
          e.mode = ($urandom_range(0, 1) == 0) ? MODE_QUERY_MOUSE : MODE_QUERY_TOUCH;
          e.id = pick_finger();
          send_event(e);
        end else begin
          e = rand_ev();
          if (e.mode == MODE_RESET && $urandom_range(0, 3) != 0) begin
            e.mode = MODE_QUERY_MOUSE;
          end
          send_event(e);
        end
      end
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Sent %0d events over %0d threshold settings; %0d reports checked.",
             items_sent, PHASES, mon_reports);
    $display("Mixed mouse and touch gestures, frames, wheel runs, queries and noise.");
    if (mon_errors == 0 && mon_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d reports still outstanding.", mon_errors, mon_pending);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
